### rtl/wmp_pkg.sv
// shared types, constants and bounds for the wkb multipolygon parser
// no dependencies; imported by every module of the block
package wmp_pkg;

    localparam int unsigned MAX_POLYGONS = 256;
    localparam int unsigned MAX_RINGS    = 256;
    localparam int unsigned MAX_POINTS   = 65536;

    localparam int unsigned POLYS_W  = $clog2(MAX_POLYGONS + 1);
    localparam int unsigned RINGS_W  = $clog2(MAX_RINGS + 1);
    localparam int unsigned POINTS_W = $clog2(MAX_POINTS + 1);

    localparam logic [7:0] TYPE_MULTIPOLYGON = 8'd6;
    localparam logic [7:0] TYPE_POLYGON      = 8'd3;
    localparam logic [3:0] COORD_LAST_BYTE   = 4'd15;
    localparam logic [3:0] WORD_LAST_BYTE    = 4'd3;

    localparam int unsigned OUT_DATA_W = 176;
    localparam int unsigned OUT_USER_W = 3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_TOP_TYPE,
        PH_POLY_COUNT,
        PH_PG_ORDER,
        PH_PG_TYPE,
        PH_RING_COUNT,
        PH_POINT_COUNT,
        PH_COORD,
        PH_WAIT
    } wmp_phase_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_TOP_TYPE   = 2'd1,
        ERR_POLY_TYPE  = 2'd2,
        ERR_COUNT_OVER = 2'd3
    } wmp_err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_record;
    } wmp_item_t;

    typedef struct packed {
        logic [63:0] x_bits;
        logic [63:0] y_bits;
        logic [7:0]  polygon_index;
        logic [7:0]  ring_index;
        logic [15:0] point_index;
        logic [15:0] ring_point_count;
        logic        last_of_ring;
        logic        last_of_record;
        wmp_err_t    error_code;
    } wmp_result_t;

    // handshake between the parse core and the two register stages
    typedef struct packed {
        logic item_valid;
        logic out_free;
    } wmp_core_in_t;

    typedef struct packed {
        logic take;
        logic load;
    } wmp_core_out_t;

endpackage

### rtl/wkb_multipolygon_parser_unit.sv
// top level of the wkb multipolygon parser: input register, parse core, result register
// depends on wmp_pkg, wmp_in_stage, wmp_parse_core, wmp_out_stage
// the byte that completes a point passes the input register, then the result register
// throughput: one byte per cycle; a byte that yields a result waits on stalled output
// reset: rst_n clears both stage valid bits and the parser to idle, waiting for a start
module wkb_multipolygon_parser_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // data_byte
    input  logic                               s_tuser,  // start_of_record
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // x_bits, y_bits, polygon_index, ring_index, point_index, ring_point_count
    output logic [wmp_pkg::OUT_DATA_W-1:0]     m_tdata,
    // last_of_ring, error_code
    output logic [wmp_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                               m_tlast   // last_of_record
);
    import wmp_pkg::*;

    wmp_item_t     s_item;
    wmp_item_t     item;
    logic          item_valid;
    wmp_core_in_t  core_in;
    wmp_core_out_t core_out;
    wmp_result_t   result;
    wmp_result_t   m_result;
    logic          out_free;

    assign s_item.data_byte       = s_tdata;
    assign s_item.start_of_record = s_tuser;

    assign core_in.item_valid = item_valid;
    assign core_in.out_free   = out_free;

    wmp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (core_out.take),
        .item_valid (item_valid),
        .item       (item)
    );

    wmp_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (core_in),
        .item    (item),
        .ctl_out (core_out),
        .result  (result)
    );

    wmp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (core_out.load),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {m_result.ring_point_count, m_result.point_index,
                      m_result.ring_index, m_result.polygon_index,
                      m_result.y_bits, m_result.x_bits};
    assign m_tuser = {m_result.error_code, m_result.last_of_ring};
    assign m_tlast = m_result.last_of_record;

endmodule

### rtl/wmp_in_stage.sv
// input register for one byte transaction
// depends on wmp_pkg
module wmp_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  wmp_pkg::wmp_item_t  s_item,
    input  logic                take,
    output logic                item_valid,
    output wmp_pkg::wmp_item_t  item
);
    import wmp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    wmp_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

### rtl/wmp_parse_core.sv
// parser state and per-byte next-state logic
// depends on wmp_pkg
module wmp_parse_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wmp_pkg::wmp_core_in_t ctl_in,
    input  wmp_pkg::wmp_item_t    item,
    output wmp_pkg::wmp_core_out_t ctl_out,
    output wmp_pkg::wmp_result_t  result
);
    import wmp_pkg::*;

    wmp_phase_t           phase_reg, phase_next;
    logic [3:0]           fbc_reg, fbc_next;
    logic [POLYS_W-1:0]   polys_left_reg, polys_left_next;
    logic [RINGS_W-1:0]   rings_left_reg, rings_left_next;
    logic [POINTS_W-1:0]  points_left_reg, points_left_next;
    logic [23:0]          count_reg, count_next;
    logic [63:0]          x_reg, x_next;
    logic [63:0]          y_reg, y_next;
    logic [7:0]           poly_cnt_reg, poly_cnt_next;
    logic [7:0]           ring_cnt_reg, ring_cnt_next;
    logic [15:0]          point_cnt_reg, point_cnt_next;
    logic [15:0]          ring_size_reg, ring_size_next;

    logic [7:0]  b;
    logic [31:0] full_count;
    logic        res_valid;
    logic        fin_ring;
    logic        fin_poly;

    assign b          = item.data_byte;
    assign full_count = {b, count_reg};

    assign ctl_out.take = ctl_in.item_valid && (!res_valid || ctl_in.out_free);
    assign ctl_out.load = ctl_out.take && res_valid;

    always_comb
    begin
        phase_next       = phase_reg;
        fbc_next         = fbc_reg;
        polys_left_next  = polys_left_reg;
        rings_left_next  = rings_left_reg;
        points_left_next = points_left_reg;
        count_next       = count_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        poly_cnt_next    = poly_cnt_reg;
        ring_cnt_next    = ring_cnt_reg;
        point_cnt_next   = point_cnt_reg;
        ring_size_next   = ring_size_reg;
        result           = '0;
        res_valid        = 1'b0;
        fin_ring         = 1'b0;
        fin_poly         = 1'b0;

        if (item.start_of_record)
        begin
            phase_next       = PH_TOP_TYPE;
            fbc_next         = '0;
            polys_left_next  = '0;
            rings_left_next  = '0;
            points_left_next = '0;
            count_next       = '0;
            x_next           = '0;
            y_next           = '0;
            poly_cnt_next    = '0;
            ring_cnt_next    = '0;
            point_cnt_next   = '0;
            ring_size_next   = '0;
        end
        else
        begin
            // byte lanes of the count word being gathered
            if ((phase_reg == PH_POLY_COUNT || phase_reg == PH_RING_COUNT ||
                 phase_reg == PH_POINT_COUNT) && fbc_reg != WORD_LAST_BYTE)
            begin
                count_next[{fbc_reg[1:0], 3'b000} +: 8] =
                    count_reg[{fbc_reg[1:0], 3'b000} +: 8] | b;
                fbc_next = fbc_reg + 4'd1;
            end

            unique case (phase_reg)
                PH_TOP_TYPE:
                begin
                    if (fbc_reg == '0 && b != TYPE_MULTIPOLYGON)
                    begin
                        result.error_code = ERR_TOP_TYPE;
                        res_valid         = 1'b1;
                        phase_next        = PH_WAIT;
                    end
                    else if (fbc_reg == WORD_LAST_BYTE)
                    begin
                        fbc_next   = '0;
                        count_next = '0;
                        phase_next = PH_POLY_COUNT;
                    end
                    else
                    begin
                        fbc_next = fbc_reg + 4'd1;
                    end
                end
                PH_POLY_COUNT:
                begin
                    if (fbc_reg == WORD_LAST_BYTE)
                    begin
                        fbc_next = '0;
                        if (full_count > 32'(MAX_POLYGONS))
                        begin
                            result.error_code = ERR_COUNT_OVER;
                            res_valid         = 1'b1;
                            phase_next        = PH_WAIT;
                        end
                        else
                        begin
                            polys_left_next = full_count[POLYS_W-1:0];
                            poly_cnt_next   = '0;
                            phase_next = (full_count == '0) ? PH_WAIT : PH_PG_ORDER;
                        end
                    end
                end
                PH_PG_ORDER:
                begin
                    fbc_next   = '0;
                    phase_next = PH_PG_TYPE;
                end
                PH_PG_TYPE:
                begin
                    if (fbc_reg == '0 && b != TYPE_POLYGON)
                    begin
                        result.error_code = ERR_POLY_TYPE;
                        res_valid         = 1'b1;
                        phase_next        = PH_WAIT;
                    end
                    else if (fbc_reg == WORD_LAST_BYTE)
                    begin
                        fbc_next   = '0;
                        count_next = '0;
                        phase_next = PH_RING_COUNT;
                    end
                    else
                    begin
                        fbc_next = fbc_reg + 4'd1;
                    end
                end
                PH_RING_COUNT:
                begin
                    if (fbc_reg == WORD_LAST_BYTE)
                    begin
                        fbc_next = '0;
                        if (full_count > 32'(MAX_RINGS))
                        begin
                            result.error_code = ERR_COUNT_OVER;
                            res_valid         = 1'b1;
                            phase_next        = PH_WAIT;
                        end
                        else
                        begin
                            rings_left_next = full_count[RINGS_W-1:0];
                            ring_cnt_next   = '0;
                            count_next      = '0;
                            if (full_count == '0)
                            begin
                                fin_poly = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_POINT_COUNT;
                            end
                        end
                    end
                end
                PH_POINT_COUNT:
                begin
                    if (fbc_reg == WORD_LAST_BYTE)
                    begin
                        fbc_next = '0;
                        if (full_count > 32'(MAX_POINTS))
                        begin
                            result.error_code = ERR_COUNT_OVER;
                            res_valid         = 1'b1;
                            phase_next        = PH_WAIT;
                        end
                        else
                        begin
                            points_left_next = full_count[POINTS_W-1:0];
                            ring_size_next   = full_count[15:0];
                            point_cnt_next   = '0;
                            if (full_count == '0)
                            begin
                                fin_ring = 1'b1;
                            end
                            else
                            begin
                                x_next     = '0;
                                y_next     = '0;
                                phase_next = PH_COORD;
                            end
                        end
                    end
                end
                PH_COORD:
                begin
                    if (!fbc_reg[3])
                    begin
                        x_next[{fbc_reg[2:0], 3'b000} +: 8] =
                            x_reg[{fbc_reg[2:0], 3'b000} +: 8] | b;
                    end
                    else
                    begin
                        y_next[{fbc_reg[2:0], 3'b000} +: 8] =
                            y_reg[{fbc_reg[2:0], 3'b000} +: 8] | b;
                    end
                    fbc_next = fbc_reg + 4'd1;
                    if (fbc_reg == COORD_LAST_BYTE)
                    begin
                        fbc_next                = '0;
                        res_valid               = 1'b1;
                        result.x_bits           = x_next;
                        result.y_bits           = y_next;
                        result.polygon_index    = poly_cnt_reg;
                        result.ring_index       = ring_cnt_reg;
                        result.point_index      = point_cnt_reg;
                        result.ring_point_count = ring_size_reg;
                        result.last_of_ring     = (points_left_reg == POINTS_W'(1));
                        result.last_of_record   = (points_left_reg == POINTS_W'(1)) &&
                                                  (rings_left_reg == RINGS_W'(1)) &&
                                                  (polys_left_reg == POLYS_W'(1));
                        result.error_code       = ERR_NONE;
                        x_next                  = '0;
                        y_next                  = '0;
                        points_left_next        = points_left_reg - POINTS_W'(1);
                        point_cnt_next          = point_cnt_reg + 16'd1;
                        if (points_left_reg == POINTS_W'(1))
                        begin
                            fin_ring = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (fin_ring)
            begin
                rings_left_next = rings_left_reg - RINGS_W'(1);
                ring_cnt_next   = ring_cnt_reg + 8'd1;
                point_cnt_next  = '0;
                fbc_next        = '0;
                count_next      = '0;
                if (rings_left_reg == RINGS_W'(1))
                begin
                    fin_poly = 1'b1;
                end
                else
                begin
                    phase_next = PH_POINT_COUNT;
                end
            end

            if (fin_poly)
            begin
                polys_left_next = polys_left_reg - POLYS_W'(1);
                poly_cnt_next   = poly_cnt_reg + 8'd1;
                ring_cnt_next   = '0;
                fbc_next        = '0;
                phase_next = (polys_left_reg == POLYS_W'(1)) ? PH_WAIT : PH_PG_ORDER;
            end
        end

        if (!ctl_in.item_valid)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            fbc_reg         <= '0;
            polys_left_reg  <= '0;
            rings_left_reg  <= '0;
            points_left_reg <= '0;
            count_reg       <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            poly_cnt_reg    <= '0;
            ring_cnt_reg    <= '0;
            point_cnt_reg   <= '0;
            ring_size_reg   <= '0;
        end
        else if (ctl_out.take)
        begin
            phase_reg       <= phase_next;
            fbc_reg         <= fbc_next;
            polys_left_reg  <= polys_left_next;
            rings_left_reg  <= rings_left_next;
            points_left_reg <= points_left_next;
            count_reg       <= count_next;
            x_reg           <= x_next;
            y_reg           <= y_next;
            poly_cnt_reg    <= poly_cnt_next;
            ring_cnt_reg    <= ring_cnt_next;
            point_cnt_reg   <= point_cnt_next;
            ring_size_reg   <= ring_size_next;
        end
    end

endmodule

### rtl/wmp_out_stage.sv
// result register holding one point or error transaction
// depends on wmp_pkg
module wmp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  wmp_pkg::wmp_result_t result,
    output logic                 out_free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output wmp_pkg::wmp_result_t m_result
);
    import wmp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    wmp_result_t result_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

### rtl/wmp_checker.sv
// port-level assertions for the wkb multipolygon parser, bound to the top level
// depends on wmp_pkg and wkb_multipolygon_parser_unit
module wmp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wmp_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [wmp_pkg::OUT_USER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import wmp_pkg::*;

    // error transaction carries nothing but its code
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:1] != ERR_NONE) |-> (m_tdata == '0 && !m_tlast && !m_tuser[0]))
        else $error("error transaction with nonzero payload");

    // end of record is always end of ring
    a_last_nesting: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("last_of_record without last_of_ring");

    // a fresh result comes from an accepted byte, registered in the input stage and then in the result stage
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding input transaction");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                     $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind wkb_multipolygon_parser_unit wmp_checker u_wmp_checker (.*);

### dv/wkb_multipolygon_parser_unit_test.sv
// self-checking testbench for wkb_multipolygon_parser_unit: byte stream in, point results out
// depends on wmp_pkg and the rtl of the unit; a class tracks the parse and holds owed points
`timescale 1ns / 1ps

module wkb_multipolygon_parser_unit_test;

    import wmp_pkg::*;

    localparam int unsigned IDLE_LIMIT = 4000;

    class wkb_point_tracker;
        wmp_phase_t  phase;
        bit [3:0]    byte_cnt;
        bit [8:0]    polys_left;
        bit [8:0]    rings_left;
        bit [16:0]   pts_left;
        bit [31:0]   count_acc;
        bit [63:0]   x_acc;
        bit [63:0]   y_acc;
        bit [7:0]    poly_no;
        bit [7:0]    ring_no;
        bit [15:0]   pt_no;
        bit [16:0]   ring_len;
        wmp_result_t owed_points[$];
        int          mismatches;

        function new();
            clear();
            phase = PH_IDLE;
            mismatches = 0;
        endfunction

        function void clear();
            byte_cnt   = '0;
            polys_left = '0;
            rings_left = '0;
            pts_left   = '0;
            count_acc  = '0;
            x_acc      = '0;
            y_acc      = '0;
            poly_no    = '0;
            ring_no    = '0;
            pt_no      = '0;
            ring_len   = '0;
        endfunction

        function int points_owed();
            return owed_points.size();
        endfunction

        function void owe_error(wmp_err_t code);
            wmp_result_t r;
            r = '0;
            r.error_code = code;
            owed_points.push_back(r);
            phase = PH_WAIT;
        endfunction

        function bit add_count_byte(bit [7:0] b);
            count_acc |= 32'(b) << (8 * byte_cnt[1:0]);
            if (byte_cnt == WORD_LAST_BYTE)
            begin
                byte_cnt = '0;
                return 1'b1;
            end
            byte_cnt++;
            return 1'b0;
        endfunction

        function void close_polygon();
            polys_left--;
            poly_no++;
            ring_no  = '0;
            byte_cnt = '0;
            phase    = (polys_left == 0) ? PH_WAIT : PH_PG_ORDER;
        endfunction

        function void close_ring();
            rings_left--;
            ring_no++;
            pt_no     = '0;
            byte_cnt  = '0;
            count_acc = '0;
            if (rings_left == 0)
                close_polygon();
            else
                phase = PH_POINT_COUNT;
        endfunction

        function void note_byte(bit [7:0] b, bit sor);
            wmp_result_t r;
            if (sor)
            begin
                clear();
                phase = PH_TOP_TYPE;
                return;
            end
            case (phase)
                PH_TOP_TYPE:
                begin
                    if (byte_cnt == 0 && b != TYPE_MULTIPOLYGON)
                    begin
                        owe_error(ERR_TOP_TYPE);
                        return;
                    end
                    if (byte_cnt == WORD_LAST_BYTE)
                    begin
                        byte_cnt  = '0;
                        count_acc = '0;
                        phase     = PH_POLY_COUNT;
                    end
                    else
                        byte_cnt++;
                end
                PH_POLY_COUNT:
                begin
                    if (add_count_byte(b))
                    begin
                        if (count_acc > MAX_POLYGONS)
                        begin
                            owe_error(ERR_COUNT_OVER);
                            return;
                        end
                        polys_left = count_acc[8:0];
                        poly_no    = '0;
                        phase      = (polys_left == 0) ? PH_WAIT : PH_PG_ORDER;
                    end
                end
                PH_PG_ORDER:
                begin
                    byte_cnt = '0;
                    phase    = PH_PG_TYPE;
                end
                PH_PG_TYPE:
                begin
                    if (byte_cnt == 0 && b != TYPE_POLYGON)
                    begin
                        owe_error(ERR_POLY_TYPE);
                        return;
                    end
                    if (byte_cnt == WORD_LAST_BYTE)
                    begin
                        byte_cnt  = '0;
                        count_acc = '0;
                        phase     = PH_RING_COUNT;
                    end
                    else
                        byte_cnt++;
                end
                PH_RING_COUNT:
                begin
                    if (add_count_byte(b))
                    begin
                        if (count_acc > MAX_RINGS)
                        begin
                            owe_error(ERR_COUNT_OVER);
                            return;
                        end
                        rings_left = count_acc[8:0];
                        ring_no    = '0;
                        count_acc  = '0;
                        if (rings_left == 0)
                            close_polygon();
                        else
                            phase = PH_POINT_COUNT;
                    end
                end
                PH_POINT_COUNT:
                begin
                    if (add_count_byte(b))
                    begin
                        if (count_acc > MAX_POINTS)
                        begin
                            owe_error(ERR_COUNT_OVER);
                            return;
                        end
                        pts_left = count_acc[16:0];
                        ring_len = count_acc[16:0];
                        pt_no    = '0;
                        if (pts_left == 0)
                            close_ring();
                        else
                        begin
                            x_acc = '0;
                            y_acc = '0;
                            phase = PH_COORD;
                        end
                    end
                end
                PH_COORD:
                begin
                    if (byte_cnt < 8)
                        x_acc |= 64'(b) << (8 * byte_cnt);
                    else
                        y_acc |= 64'(b) << (8 * (byte_cnt - 8));
                    if (byte_cnt != COORD_LAST_BYTE)
                    begin
                        byte_cnt++;
                        return;
                    end
                    byte_cnt = '0;
                    r = '0;
                    r.x_bits           = x_acc;
                    r.y_bits           = y_acc;
                    r.polygon_index    = poly_no;
                    r.ring_index       = ring_no;
                    r.point_index      = pt_no;
                    r.ring_point_count = ring_len[15:0];
                    r.last_of_ring     = (pts_left == 1);
                    r.last_of_record   = (pts_left == 1) && (rings_left == 1)
                                         && (polys_left == 1);
                    r.error_code       = ERR_NONE;
                    owed_points.push_back(r);
                    x_acc = '0;
                    y_acc = '0;
                    pts_left--;
                    pt_no++;
                    if (pts_left == 0)
                        close_ring();
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_point(logic [OUT_DATA_W-1:0] tdata, logic [OUT_USER_W-1:0] tuser,
                                  logic tlast);
            wmp_result_t e;
            if (owed_points.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual tdata %h tuser %h",
                         $time, tdata, tuser);
                mismatches++;
                return;
            end
            e = owed_points.pop_front();
            compare_field("x_bits", e.x_bits, tdata[63:0]);
            compare_field("y_bits", e.y_bits, tdata[127:64]);
            compare_field("polygon_index", 64'(e.polygon_index), 64'(tdata[135:128]));
            compare_field("ring_index", 64'(e.ring_index), 64'(tdata[143:136]));
            compare_field("point_index", 64'(e.point_index), 64'(tdata[159:144]));
            compare_field("ring_point_count", 64'(e.ring_point_count), 64'(tdata[175:160]));
            compare_field("last_of_ring", 64'(e.last_of_ring), 64'(tuser[0]));
            compare_field("error_code", 64'(e.error_code), 64'(tuser[2:1]));
            compare_field("last_of_record", 64'(e.last_of_record), 64'(tlast));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    wkb_point_tracker points = new();
    bit          no_idle = 1'b0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned bytes_sent = 0;

    wkb_multipolygon_parser_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned pick_delay();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [7:0] pick_other(bit [7:0] v);
        bit [7:0] b;
        do
            b = 8'($urandom);
        while (b == v);
        return b;
    endfunction

    function automatic bit [31:0] over_count(int unsigned bound);
        if ($urandom_range(0, 1))
            return bound + $urandom_range(1, 50);
        return $urandom | 32'h0100_0000;
    endfunction

    function automatic int unsigned small_count(int unsigned hi);
        if ($urandom_range(0, 9) == 0)
            return 0;
        return $urandom_range(1, hi);
    endfunction

    // receiver stalls
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 40);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            points.note_byte(s_tdata, s_tuser);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            points.check_point(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL wkb_multipolygon_parser_unit");
                $finish;
            end
        end
    end

    task automatic push_byte(bit [7:0] b, bit sor);
        int unsigned gap;
        gap = no_idle ? 0 : pick_delay();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sor;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic push_word(bit [31:0] w);
        for (int i = 0; i < 4; i++)
            push_byte(w[8*i +: 8], 1'b0);
    endtask

    // type word: only the low byte matters, the rest is random
    task automatic push_type(bit [7:0] low);
        push_byte(low, 1'b0);
        repeat (3) push_byte(8'($urandom), 1'b0);
    endtask

    task automatic push_point(bit [63:0] x, bit [63:0] y);
        for (int i = 0; i < 8; i++)
            push_byte(x[8*i +: 8], 1'b0);
        for (int i = 0; i < 8; i++)
            push_byte(y[8*i +: 8], 1'b0);
    endtask

    task automatic push_random_point();
        push_point({$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic push_rec_head(bit [31:0] poly_count);
        push_byte(8'($urandom), 1'b1);
        push_type(TYPE_MULTIPOLYGON);
        push_word(poly_count);
    endtask

    task automatic push_poly_head(bit [31:0] ring_count);
        push_byte(8'($urandom), 1'b0);
        push_type(TYPE_POLYGON);
        push_word(ring_count);
    endtask

    task automatic push_noise();
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (points.points_owed() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic push_random_record();
        int unsigned kind;
        int unsigned npoly;
        int unsigned nring;
        int unsigned npts;
        kind = $urandom_range(0, 15);
        no_idle = ($urandom_range(0, 5) == 0);
        push_byte(8'($urandom), 1'b1);
        if (kind == 1)
        begin
            push_type(pick_other(TYPE_MULTIPOLYGON));
            push_noise();
            return;
        end
        push_type(TYPE_MULTIPOLYGON);
        if (kind == 2)
        begin
            push_word(over_count(MAX_POLYGONS));
            push_noise();
            return;
        end
        npoly = small_count(2);
        push_word(npoly);
        for (int unsigned p = 0; p < npoly; p++)
        begin
            push_byte(8'($urandom), 1'b0);
            if (kind == 3 && p == npoly - 1)
            begin
                push_type(pick_other(TYPE_POLYGON));
                push_noise();
                return;
            end
            push_type(TYPE_POLYGON);
            if (kind == 4 && p == npoly - 1)
            begin
                push_word(over_count(MAX_RINGS));
                push_noise();
                return;
            end
            nring = small_count(2);
            push_word(nring);
            for (int unsigned r = 0; r < nring; r++)
            begin
                if (kind == 5 && p == npoly - 1 && r == nring - 1)
                begin
                    push_word(over_count(MAX_POINTS));
                    push_noise();
                    return;
                end
                npts = small_count(3);
                push_word(npts);
                for (int unsigned i = 0; i < npts; i++)
                begin
                    // cut the record short; the next start takes over
                    if (kind == 6 && $urandom_range(0, 3) == 0)
                    begin
                        repeat ($urandom_range(0, 15)) push_byte(8'($urandom), 1'b0);
                        return;
                    end
                    push_random_point();
                end
            end
        end
        if (kind == 7)
            push_noise();
    endtask

    initial
    begin
        int unsigned random_goal;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes before any start
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(TYPE_MULTIPOLYGON, 1'b0);

        // bad top type, then ignored bytes
        push_byte(8'h01, 1'b1);
        push_type(8'h86);
        push_byte(8'hff, 1'b0);

        // empty multipolygon
        push_rec_head(32'd0);
        push_byte(8'h55, 1'b0);

        // counts over bound
        push_rec_head(MAX_POLYGONS + 1);
        push_rec_head(32'hffff_ffff);
        push_rec_head(32'd1);
        push_poly_head(MAX_RINGS + 1);
        push_rec_head(32'd1);
        push_poly_head(32'd1);
        push_word(MAX_POINTS + 1);

        // bad polygon type
        push_rec_head(32'd1);
        push_byte(8'h01, 1'b0);
        push_type(8'hff);

        // empty polygon and empty ring before the points, extreme coordinates
        push_rec_head(32'd2);
        push_poly_head(32'd0);
        push_poly_head(32'd3);
        push_word(32'd0);
        push_word(32'd1);
        push_point(64'hffff_ffff_ffff_ffff, 64'h0);
        push_word(32'd2);
        push_point(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        push_point(64'h8000_0000_0000_0001, 64'h7ff0_0000_0000_0000);

        // trailing empty ring: no point carries the record end mark
        push_rec_head(32'd1);
        push_poly_head(32'd2);
        push_word(32'd1);
        push_random_point();
        push_word(32'd0);

        // restart in the middle of a point
        push_rec_head(32'd1);
        push_poly_head(32'd1);
        push_word(32'd1);
        repeat (7) push_byte(8'($urandom), 1'b0);
        push_rec_head(32'd1);
        push_poly_head(32'd1);
        push_word(32'd1);
        push_random_point();

        wait_drained();

        // largest polygon, ring and point counts, each record cut short by the next start
        no_idle = 1'b1;
        push_rec_head(MAX_POLYGONS);
        for (int i = 0; i < 3; i++)
        begin
            push_poly_head(32'd1);
            push_word(32'd1);
            push_random_point();
        end
        no_idle = 1'b0;
        push_rec_head(32'd1);
        push_poly_head(MAX_RINGS);
        for (int i = 0; i < 3; i++)
        begin
            push_word(32'd1);
            push_random_point();
        end
        push_rec_head(32'd1);
        push_poly_head(32'd1);
        push_word(MAX_POINTS);
        repeat (20) push_random_point();

        random_goal = 2000;
        while (bytes_sent < random_goal)
        begin
            push_random_record();
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        if (points.mismatches == 0)
            $display("PASS wkb_multipolygon_parser_unit");
        else
            $display("FAIL wkb_multipolygon_parser_unit");
        $finish;
    end

endmodule
